>>> rtl/bwvb_pkg.sv
// shared types and constants for the bilinear weighted view blend
package bwvb_pkg;

  localparam int unsigned FRAC_BITS    = 11;
  localparam int unsigned FRAC_W       = 11;
  localparam int unsigned K_W          = FRAC_BITS + 1;
  localparam logic [K_W-1:0] K_ONE     = K_W'(1) << FRAC_BITS;
  localparam int unsigned PIX_W        = 24;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned NUM_CH       = 3;
  localparam int unsigned WGT_W        = 13;
  localparam int unsigned WV_W         = WGT_W + CH_W;
  localparam int unsigned LERP_W       = CH_W + K_W;
  localparam int unsigned VSUM_W       = LERP_W + K_W;
  localparam int unsigned INTERP_SHIFT = 2 * FRAC_BITS;
  localparam int unsigned CH_ACC_W     = 23;
  localparam int unsigned W_ACC_W      = 16;
  localparam int unsigned REM_W        = CH_ACC_W + 1;
  localparam int unsigned QUO_W        = CH_W;
  localparam logic [CH_W-1:0] CH_MAX   = {CH_W{1'b1}};

  // divider sequencer steps
  localparam int unsigned STEP_W             = 4;
  localparam logic [STEP_W-1:0] STEP_ROUND   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RANGE   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST    = 4'd9;

  typedef struct packed {
    logic                contribution_valid;
    logic [FRAC_W-1:0]   frac_x;
    logic [FRAC_W-1:0]   frac_y;
    logic [PIX_W-1:0]    pixel_top_left;
    logic [PIX_W-1:0]    pixel_top_right;
    logic [PIX_W-1:0]    pixel_bottom_left;
    logic [PIX_W-1:0]    pixel_bottom_right;
    logic [WGT_W-1:0]    blend_weight;
    logic                last_camera;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] out_channel0;
    logic [CH_W-1:0] out_channel1;
    logic [CH_W-1:0] out_channel2;
    logic            no_coverage;
  } out_word_t;

  // one classified contribution handed from front to back
  typedef struct packed {
    logic                          contrib;
    logic                          last;
    logic [WGT_W-1:0]              weight;
    logic [NUM_CH-1:0][WV_W-1:0]   wval;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

>>> rtl/bwvb_front.sv
// front pipeline: bilinear interpolation and weighting of each contribution
module bwvb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bwvb_pkg::in_word_t in_word_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output bwvb_pkg::q_entry_t q_entry_o
);
  import bwvb_pkg::*;

  logic adv;

  // stage 1: kernel weights
  logic                             s1_valid_q;
  logic                             s1_contrib_q, s1_last_q;
  logic [WGT_W-1:0]                 s1_w_q;
  logic [K_W-1:0]                   s1_kx0_q, s1_kx1_q, s1_ky0_q, s1_ky1_q;
  logic [PIX_W-1:0]                 s1_tl_q, s1_tr_q, s1_bl_q, s1_br_q;

  // stage 2: horizontal lerp
  logic                             s2_valid_q;
  logic                             s2_contrib_q, s2_last_q;
  logic [WGT_W-1:0]                 s2_w_q;
  logic [K_W-1:0]                   s2_ky0_q, s2_ky1_q;
  logic [NUM_CH-1:0][LERP_W-1:0]    s2_top_q, s2_bot_q;
  logic [NUM_CH-1:0][LERP_W-1:0]    s2_top_d, s2_bot_d;

  // stage 3: vertical lerp
  logic                             s3_valid_q;
  logic                             s3_contrib_q, s3_last_q;
  logic [WGT_W-1:0]                 s3_w_q;
  logic [NUM_CH-1:0][CH_W-1:0]      s3_v_q, s3_v_d;
  logic [NUM_CH-1:0][VSUM_W-1:0]    vsum;

  // stage 4: weighted value
  logic                             s4_valid_q;
  logic                             s4_contrib_q, s4_last_q;
  logic [WGT_W-1:0]                 s4_w_q;
  logic [NUM_CH-1:0][WV_W-1:0]      s4_wv_q, s4_wv_d;

  // the whole pipe holds when the last stage cannot enter the queue
  assign adv        = !(s4_valid_q && q_full_i);
  assign in_stall_o = !adv;
  assign q_push_o   = s4_valid_q && !q_full_i;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s2_top_d[c] = LERP_W'(s1_tl_q[CH_W*c +: CH_W]) * LERP_W'(s1_kx0_q)
                  + LERP_W'(s1_tr_q[CH_W*c +: CH_W]) * LERP_W'(s1_kx1_q);
      s2_bot_d[c] = LERP_W'(s1_bl_q[CH_W*c +: CH_W]) * LERP_W'(s1_kx0_q)
                  + LERP_W'(s1_br_q[CH_W*c +: CH_W]) * LERP_W'(s1_kx1_q);
      vsum[c]     = VSUM_W'(s2_top_q[c]) * VSUM_W'(s2_ky0_q)
                  + VSUM_W'(s2_bot_q[c]) * VSUM_W'(s2_ky1_q);
      s3_v_d[c]   = vsum[c][INTERP_SHIFT +: CH_W];
      s4_wv_d[c]  = WV_W'(s3_w_q) * WV_W'(s3_v_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // an 11-bit fraction never exceeds one, so no clamp is needed
      s1_contrib_q <= in_word_i.contribution_valid;
      s1_last_q    <= in_word_i.last_camera;
      s1_w_q       <= in_word_i.blend_weight;
      s1_kx1_q     <= K_W'(in_word_i.frac_x);
      s1_kx0_q     <= K_ONE - K_W'(in_word_i.frac_x);
      s1_ky1_q     <= K_W'(in_word_i.frac_y);
      s1_ky0_q     <= K_ONE - K_W'(in_word_i.frac_y);
      s1_tl_q      <= in_word_i.pixel_top_left;
      s1_tr_q      <= in_word_i.pixel_top_right;
      s1_bl_q      <= in_word_i.pixel_bottom_left;
      s1_br_q      <= in_word_i.pixel_bottom_right;

      s2_contrib_q <= s1_contrib_q;
      s2_last_q    <= s1_last_q;
      s2_w_q       <= s1_w_q;
      s2_ky0_q     <= s1_ky0_q;
      s2_ky1_q     <= s1_ky1_q;
      s2_top_q     <= s2_top_d;
      s2_bot_q     <= s2_bot_d;

      s3_contrib_q <= s2_contrib_q;
      s3_last_q    <= s2_last_q;
      s3_w_q       <= s2_w_q;
      s3_v_q       <= s3_v_d;

      s4_contrib_q <= s3_contrib_q;
      s4_last_q    <= s3_last_q;
      s4_w_q       <= s3_w_q;
      s4_wv_q      <= s4_wv_d;
    end
  end

  always_comb begin
    q_entry_o.contrib = s4_contrib_q;
    q_entry_o.last    = s4_last_q;
    q_entry_o.weight  = s4_w_q;
    q_entry_o.wval    = s4_wv_q;
  end

endmodule

>>> rtl/bwvb_queue.sv
// small first-in first-out queue between front and back
module bwvb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bwvb_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output bwvb_pkg::q_entry_t entry_o,
  output logic               full_o,
  output logic               empty_o
);
  import bwvb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  q_entry_t          slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/bwvb_back.sv
// back end: saturating accumulation and rounded per-pixel division
module bwvb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  bwvb_pkg::q_entry_t  q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bwvb_pkg::out_word_t out_word_o
);
  import bwvb_pkg::*;

  back_state_e state_q, state_d;

  logic [NUM_CH-1:0][CH_ACC_W-1:0] acc_q, acc_next;
  logic [W_ACC_W-1:0]              wacc_q, wacc_next;
  logic [NUM_CH-1:0][CH_ACC_W:0]   acc_sum;
  logic [W_ACC_W:0]                wacc_sum;

  logic [NUM_CH-1:0][REM_W-1:0]    rem_q;
  logic [NUM_CH-1:0][QUO_W-1:0]    quo_q;
  logic [NUM_CH-1:0]               sat_q;
  logic [W_ACC_W-1:0]              den_q;
  logic [REM_W-1:0]                dsh_q;
  logic [STEP_W-1:0]               step_q;
  logic                            zero_q;

  logic                            out_valid_q;
  out_word_t                       out_q;
  logic                            out_free;
  logic                            pop_last;
  logic [NUM_CH-1:0][CH_W-1:0]     ch_res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // saturating accumulate of the word at the queue head
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_sum[c]  = (CH_ACC_W + 1)'(acc_q[c]) + (CH_ACC_W + 1)'(q_entry_i.wval[c]);
      acc_next[c] = acc_q[c];
      if (q_entry_i.contrib) begin
        acc_next[c] = acc_sum[c][CH_ACC_W] ? {CH_ACC_W{1'b1}} : acc_sum[c][CH_ACC_W-1:0];
      end
    end
    wacc_sum  = (W_ACC_W + 1)'(wacc_q) + (W_ACC_W + 1)'(q_entry_i.weight);
    wacc_next = wacc_q;
    if (q_entry_i.contrib) begin
      wacc_next = wacc_sum[W_ACC_W] ? {W_ACC_W{1'b1}} : wacc_sum[W_ACC_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC: begin
        if (!q_empty_i && q_entry_i.last) begin
          state_d = (wacc_next == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop_o = 1'b0;
    case (state_q)
      ST_ACC:  q_pop_o = !q_empty_i;
      ST_DIV:  q_pop_o = 1'b0;
      ST_EMIT: q_pop_o = 1'b0;
      default: q_pop_o = 1'b0;
    endcase
  end

  assign pop_last = q_pop_o && q_entry_i.last;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ch_res[c] = zero_q ? '0 : (sat_q[c] ? CH_MAX : quo_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      acc_q       <= '0;
      wacc_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        if (q_entry_i.last) begin
          acc_q  <= '0;
          wacc_q <= '0;
        end else begin
          acc_q  <= acc_next;
          wacc_q <= wacc_next;
        end
      end
      if (pop_last) begin
        step_q <= STEP_ROUND;
      end else if (state_q == ST_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider lanes: round bias, range check, then eight restoring steps
  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_q[c] <= REM_W'(acc_next[c]);
        quo_q[c] <= '0;
      end
      den_q  <= wacc_next;
      zero_q <= (wacc_next == '0);
    end else if (state_q == ST_DIV) begin
      if (step_q == STEP_ROUND) begin
        for (int c = 0; c < NUM_CH; c++) begin
          rem_q[c] <= rem_q[c] + REM_W'(den_q >> 1);
        end
        dsh_q <= {den_q, {QUO_W{1'b0}}};
      end else if (step_q == STEP_RANGE) begin
        // quotient above the channel range saturates
        for (int c = 0; c < NUM_CH; c++) begin
          sat_q[c] <= (rem_q[c] >= dsh_q);
        end
        dsh_q <= dsh_q >> 1;
      end else begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (rem_q[c] >= dsh_q) begin
            rem_q[c] <= rem_q[c] - dsh_q;
            quo_q[c] <= {quo_q[c][QUO_W-2:0], 1'b1};
          end else begin
            quo_q[c] <= {quo_q[c][QUO_W-2:0], 1'b0};
          end
        end
        dsh_q <= dsh_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_q.out_channel0 <= ch_res[0];
      out_q.out_channel1 <= ch_res[1];
      out_q.out_channel2 <= ch_res[2];
      out_q.no_coverage  <= zero_q;
    end
  end

endmodule

>>> rtl/bilinear_weighted_view_blend.sv
// top level of the bilinear weighted view blend
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | one camera contribution
//  out     | output    | out_valid_o / out_stall_i | one blended pixel
//
// a contribution passes the front pipeline stages (kernel weights,
// horizontal lerp, vertical lerp, weight multiply) and enters the queue
// the back pops one queued word per cycle while it accumulates; a last
// word with coverage adds ten divider steps and an emit step, and a pixel
// that no camera covers goes straight to the emit step
// reset clears the pipeline valids, the queue, the accumulators and the
// output valid flag; no clearing pass is needed
// a full queue stalls the whole front; a held output keeps the back in its
// emit step, so the queue fills and then stalls the front as well
module bilinear_weighted_view_blend #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bwvb_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bwvb_pkg::out_word_t out_word_o
);
  import bwvb_pkg::*;

  // front to queue
  logic     q_push;
  q_entry_t q_entry_in;
  // queue to back
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_entry_out;

  // interpolation and weighting pipeline
  bwvb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry_in)
  );

  // decouples the front pipeline from the divider
  bwvb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .pop_i   (q_pop),
    .entry_o (q_entry_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // accumulation, division and output register
  bwvb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_entry_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef ASSERT_OFF
  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue push while full");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue pop while empty");

  // an uncovered pixel is black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.no_coverage) |->
      (out_word_o.out_channel0 == '0 && out_word_o.out_channel1 == '0 &&
       out_word_o.out_channel2 == '0))
    else $error("uncovered pixel not black");

  // input stalls only when the queue is full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled with queue space");
`endif

endmodule
